FILE: rtl/core/ssrd_pkg.sv
package ssrd_pkg;

    localparam int FIELD_BITS_DEF = 12;

    localparam int DEC_W     = 20;
    localparam int RAW_EXT_W = 17;
    localparam int RAW_LO_W  = 13;
    localparam int Z_W       = 17;
    localparam int E_W       = 23;
    localparam int ACC_W     = 36;
    localparam int OPB_W     = 24;
    localparam int PROD_W    = ACC_W + OPB_W;
    localparam int VWC_W     = 16;
    localparam int COND_W    = 15;
    localparam int TEMP_W    = 16;
    localparam int PC_W      = 3;
    localparam int K_W       = 2;
    localparam int RECIP_SH  = 22;
    localparam int FRAC_SH   = 16;
    localparam int OUT_SH    = 30;
    localparam int V_W       = PROD_W - OUT_SH;

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [RAW_EXT_W-1:0] RAW_E_SAT = 17'd6400;
    localparam logic [Z_W-1:0]       Z_BIAS    = 17'd12;
    localparam logic [E_W-1:0]       E_MAX     = 23'h7FFFFF;

    localparam logic signed [OPB_W-1:0] RECIP25 = 24'sd167773;
    localparam logic signed [OPB_W-1:0] K1310   = 24'sd1310;
    localparam logic signed [OPB_W-1:0] SCALE   = 24'sd10000;

    localparam logic signed [ACC_W-1:0] C3 = 36'sd4617;
    localparam logic signed [ACC_W-1:0] C2 = -36'sd590558;
    localparam logic signed [ACC_W-1:0] C1 = 36'sd31353261;
    localparam logic signed [ACC_W-1:0] C0 = -36'sd56908317;

    localparam logic signed [PROD_W-1:0] HALF_FRAC = 60'sd32768;
    localparam logic signed [PROD_W-1:0] HALF_OUT  = 60'sd536870912;

    localparam logic signed [VWC_W-1:0] VWC_MIN = -16'sd10000;
    localparam logic signed [VWC_W-1:0] VWC_MAX = 16'sd20000;

    localparam logic [DEC_W-1:0] KNEE_C    = 20'd700;
    localparam logic [DEC_W-1:0] KNEE_T    = 20'd900;
    localparam logic [DEC_W-1:0] T_OFS     = 20'd400;
    localparam logic [DEC_W-1:0] C_SAT     = 20'd32767;
    localparam logic [DEC_W-1:0] T_SAT_IN  = 20'd33167;
    localparam logic [COND_W-1:0]        COND_MAX = 15'h7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;

    localparam logic [PC_W-1:0] PC_LOOP     = 3'd3;
    localparam logic [PC_W-1:0] PC_LAST     = 3'd6;
    localparam logic [K_W-1:0]  HORNER_LAST = 2'd2;

    typedef enum logic [1:0] {A_Z, A_RAW, A_ACC} t_asel;
    typedef enum logic [1:0] {B_RECIP, B_K1310, B_E, B_SCALE} t_bsel;
    typedef enum logic [1:0] {E_HOLD, E_QUOT, E_SUM} t_eop;
    typedef enum logic [1:0] {ACC_HOLD, ACC_C3, ACC_HORNER} t_accop;

    typedef struct packed {
        logic            mul_en;
        t_asel           a_sel;
        t_bsel           b_sel;
        t_eop            e_op;
        t_accop          acc_op;
        logic            loop;
        logic [PC_W-1:0] target;
        logic            res_en;
        logic            last;
    } t_uop;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        unique case (pc)
            3'd0: begin
                u.mul_en = 1'b1;
                u.a_sel  = A_Z;
                u.b_sel  = B_RECIP;
            end
            3'd1: begin
                u.mul_en = 1'b1;
                u.a_sel  = A_RAW;
                u.b_sel  = B_K1310;
                u.e_op   = E_QUOT;
            end
            3'd2: begin
                u.e_op   = E_SUM;
                u.acc_op = ACC_C3;
            end
            3'd3: begin
                u.mul_en = 1'b1;
                u.a_sel  = A_ACC;
                u.b_sel  = B_E;
            end
            3'd4: begin
                u.acc_op = ACC_HORNER;
                u.loop   = 1'b1;
                u.target = PC_LOOP;
            end
            3'd5: begin
                u.mul_en = 1'b1;
                u.a_sel  = A_ACC;
                u.b_sel  = B_SCALE;
            end
            3'd6: begin
                u.res_en = 1'b1;
                u.last   = 1'b1;
            end
            default: begin
                u.last = 1'b1;
            end
        endcase
        return u;
    endfunction

    function automatic logic signed [ACC_W-1:0] coef(input logic [K_W-1:0] k);
        logic signed [ACC_W-1:0] c;
        unique case (k)
            2'd0:    c = C2;
            2'd1:    c = C1;
            default: c = C0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/ssrd_rx_if.sv
interface ssrd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/ssrd_res_if.sv
interface ssrd_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] moisture_vwc;
    logic [14:0]        conductivity_centi;
    logic signed [15:0] temperature_deci;
    logic               field_overflow;

    modport source (output valid, output moisture_vwc, output conductivity_centi,
                    output temperature_deci, output field_overflow, input ready);
    modport sink (input valid, input moisture_vwc, input conductivity_centi,
                  input temperature_deci, input field_overflow, output ready);
endinterface

FILE: rtl/core/ssrd_seq.sv
module ssrd_seq #(
    parameter int FIELD_BITS = ssrd_pkg::FIELD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [FIELD_BITS-1:0]               i_raw,
    input  logic                                i_take,
    output ssrd_pkg::t_seq_stat                 o_stat,
    output logic signed [ssrd_pkg::VWC_W-1:0]   o_moisture
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_seq_state;

    t_seq_state r_state, n_state;
    logic [ssrd_pkg::PC_W-1:0] r_pc, n_pc;
    logic [ssrd_pkg::K_W-1:0]  r_k, n_k;

    logic [ssrd_pkg::RAW_LO_W-1:0]       r_raw_lo;
    logic                                r_sat;
    logic [ssrd_pkg::E_W-1:0]            r_e;
    logic signed [ssrd_pkg::ACC_W-1:0]   r_acc;
    logic signed [ssrd_pkg::PROD_W-1:0]  r_prod;
    logic signed [ssrd_pkg::VWC_W-1:0]   r_vwc;

    logic [ssrd_pkg::RAW_EXT_W-1:0]      raw_ext;
    ssrd_pkg::t_uop                      uop;
    logic [ssrd_pkg::Z_W-1:0]            z;
    logic signed [ssrd_pkg::ACC_W-1:0]   op_a;
    logic signed [ssrd_pkg::OPB_W-1:0]   op_b;
    logic signed [ssrd_pkg::PROD_W-1:0]  n_prod;
    logic signed [ssrd_pkg::PROD_W-1:0]  frac_sum;
    logic signed [ssrd_pkg::PROD_W-1:0]  out_sum;
    logic signed [ssrd_pkg::V_W-1:0]     v;
    logic signed [ssrd_pkg::VWC_W-1:0]   n_vwc;
    logic running;

    assign raw_ext = ssrd_pkg::RAW_EXT_W'(i_raw);
    assign uop     = ssrd_pkg::uop_rom(r_pc);
    assign running = (r_state == S_RUN);

    assign z = {r_raw_lo, 4'b0000} + {3'b000, r_raw_lo, 1'b0} + ssrd_pkg::Z_BIAS;

    always_comb begin
        unique case (uop.a_sel)
            ssrd_pkg::A_Z:   op_a = ssrd_pkg::ACC_W'(z);
            ssrd_pkg::A_RAW: op_a = ssrd_pkg::ACC_W'(r_raw_lo);
            ssrd_pkg::A_ACC: op_a = r_acc;
            default:         op_a = '0;
        endcase
        unique case (uop.b_sel)
            ssrd_pkg::B_RECIP: op_b = ssrd_pkg::RECIP25;
            ssrd_pkg::B_K1310: op_b = ssrd_pkg::K1310;
            ssrd_pkg::B_E:     op_b = ssrd_pkg::OPB_W'(r_e);
            default:           op_b = ssrd_pkg::SCALE;
        endcase
    end

    assign n_prod   = op_a * op_b;
    assign frac_sum = r_prod + ssrd_pkg::HALF_FRAC;
    assign out_sum  = r_prod + ssrd_pkg::HALF_OUT;
    assign v        = out_sum[ssrd_pkg::PROD_W-1:ssrd_pkg::OUT_SH];

    always_comb begin
        priority if (v < ssrd_pkg::VWC_MIN) begin
            n_vwc = ssrd_pkg::VWC_MIN;
        end else if (v > ssrd_pkg::VWC_MAX) begin
            n_vwc = ssrd_pkg::VWC_MAX;
        end else begin
            n_vwc = v[ssrd_pkg::VWC_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_pc    = '0;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (uop.last) begin
                    n_state = S_DONE;
                end else if (uop.loop && (r_k != ssrd_pkg::HORNER_LAST)) begin
                    n_pc = uop.target;
                    n_k  = r_k + 1'b1;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_raw_lo <= raw_ext[ssrd_pkg::RAW_LO_W-1:0];
            r_sat    <= (raw_ext >= ssrd_pkg::RAW_E_SAT);
        end
        if (running && uop.mul_en) begin
            r_prod <= n_prod;
        end
        if (running) begin
            unique case (uop.e_op)
                ssrd_pkg::E_QUOT: r_e <= r_prod[ssrd_pkg::RECIP_SH +: ssrd_pkg::E_W];
                ssrd_pkg::E_SUM:  r_e <= r_sat ? ssrd_pkg::E_MAX
                                               : r_prod[ssrd_pkg::E_W-1:0] + r_e;
                default:          r_e <= r_e;
            endcase
            unique case (uop.acc_op)
                ssrd_pkg::ACC_C3:     r_acc <= ssrd_pkg::C3;
                ssrd_pkg::ACC_HORNER: r_acc <= frac_sum[ssrd_pkg::FRAC_SH +: ssrd_pkg::ACC_W]
                                               + ssrd_pkg::coef(r_k);
                default:              r_acc <= r_acc;
            endcase
            if (uop.res_en) begin
                r_vwc <= n_vwc;
            end
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_moisture  = r_vwc;

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        running |-> (r_pc <= ssrd_pkg::PC_LAST))
        else $error("Step counter ran past the end of the program.");

    a_loop_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        running |-> (r_k <= ssrd_pkg::HORNER_LAST))
        else $error("Horner loop count exceeded the number of coefficients.");

endmodule

FILE: rtl/core/soil_sensor_response_decoder_top.sv
// Bytes of the reply are taken one per cycle while no moisture result is in progress.
// A carriage return that completes a reply starts an 11-step microcode program on the
// shared multiplier; the result is presented once the program finishes and the output register can take it.
// Input stalls from that byte until the result moves into the output register.
// Synchronous active-low reset returns the parser to seeking the first digit,
// clears the raw fields and the overflow flag, and empties the output register.
module soil_sensor_response_decoder_top #(
    parameter int FIELD_BITS = ssrd_pkg::FIELD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssrd_rx_if.sink     i_rx,
    ssrd_res_if.source  o_res
);

    localparam int ACCX_W = FIELD_BITS + 4;
    localparam logic [ACCX_W-1:0] FIELD_MAX = ACCX_W'((1 << FIELD_BITS) - 1);

    typedef enum logic [3:0] {
        P_SEEK = 4'b0001,
        P_DIEL = 4'b0010,
        P_COND = 4'b0100,
        P_TEMP = 4'b1000
    } t_phase;

    t_phase r_phase, n_phase;
    logic [FIELD_BITS-1:0] r_diel, n_diel;
    logic [FIELD_BITS-1:0] r_cond, n_cond;
    logic [FIELD_BITS-1:0] r_facc, n_facc;
    logic                  r_ovf, n_ovf;

    logic [ssrd_pkg::COND_W-1:0]        r_pend_cond;
    logic signed [ssrd_pkg::TEMP_W-1:0] r_pend_temp;
    logic                               r_pend_ovf;

    logic                               r_out_valid;
    logic signed [ssrd_pkg::VWC_W-1:0]  r_out_moist;
    logic [ssrd_pkg::COND_W-1:0]        r_out_cond;
    logic signed [ssrd_pkg::TEMP_W-1:0] r_out_temp;
    logic                               r_out_ovf;

    ssrd_pkg::t_seq_stat                seq_stat;
    logic signed [ssrd_pkg::VWC_W-1:0]  seq_moist;

    logic                        rx_acc;
    logic                        is_digit;
    logic                        is_cr;
    logic                        is_sp;
    logic [3:0]                  digit_val;
    logic [ACCX_W-1:0]           facc_x;
    logic [ACCX_W-1:0]           nxt;
    logic                        seq_start;
    logic                        take;
    logic [ssrd_pkg::DEC_W-1:0]  c_ext, c_dec;
    logic [ssrd_pkg::DEC_W-1:0]  t_ext, t_dec;
    logic [ssrd_pkg::COND_W-1:0] cond_res;
    logic signed [ssrd_pkg::TEMP_W-1:0] temp_res;

    assign i_rx.ready = !seq_stat.busy;
    assign rx_acc     = i_rx.valid && i_rx.ready;

    assign is_digit  = (i_rx.rx_byte >= ssrd_pkg::CH_ZERO) && (i_rx.rx_byte <= ssrd_pkg::CH_NINE);
    assign is_cr     = (i_rx.rx_byte == ssrd_pkg::CH_CR);
    assign is_sp     = (i_rx.rx_byte == ssrd_pkg::CH_SP);
    assign digit_val = 4'(i_rx.rx_byte - ssrd_pkg::CH_ZERO);

    assign facc_x = ACCX_W'(r_facc);
    assign nxt    = (facc_x << 3) + (facc_x << 1) + ACCX_W'(digit_val);

    assign seq_start = rx_acc && is_cr && (r_phase == P_TEMP);

    always_comb begin
        n_phase = r_phase;
        n_diel  = r_diel;
        n_cond  = r_cond;
        n_facc  = r_facc;
        n_ovf   = r_ovf;
        if (rx_acc) begin
            if (r_phase == P_SEEK) begin
                if (is_digit) begin
                    n_facc  = FIELD_BITS'(digit_val);
                    n_phase = P_DIEL;
                end
            end else if (is_digit) begin
                if (nxt > FIELD_MAX) begin
                    n_facc = FIELD_MAX[FIELD_BITS-1:0];
                    n_ovf  = 1'b1;
                end else begin
                    n_facc = nxt[FIELD_BITS-1:0];
                end
            end else if (is_sp) begin
                if (r_phase == P_DIEL) begin
                    n_diel  = r_facc;
                    n_facc  = '0;
                    n_phase = P_COND;
                end else if (r_phase == P_COND) begin
                    n_cond  = r_facc;
                    n_facc  = '0;
                    n_phase = P_TEMP;
                end
            end else if (is_cr) begin
                n_phase = P_SEEK;
                n_diel  = '0;
                n_cond  = '0;
                n_facc  = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_SEEK;
            r_diel  <= '0;
            r_cond  <= '0;
            r_facc  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_diel  <= n_diel;
            r_cond  <= n_cond;
            r_facc  <= n_facc;
            r_ovf   <= n_ovf;
        end
    end

    assign c_ext = ssrd_pkg::DEC_W'(r_cond);
    assign t_ext = ssrd_pkg::DEC_W'(r_facc);

    always_comb begin
        if (c_ext > ssrd_pkg::KNEE_C) begin
            c_dec = ((c_ext - ssrd_pkg::KNEE_C) << 2) + (c_ext - ssrd_pkg::KNEE_C)
                    + ssrd_pkg::KNEE_C;
        end else begin
            c_dec = c_ext;
        end
        if (t_ext > ssrd_pkg::KNEE_T) begin
            t_dec = ((t_ext - ssrd_pkg::KNEE_T) << 2) + (t_ext - ssrd_pkg::KNEE_T)
                    + ssrd_pkg::KNEE_T;
        end else begin
            t_dec = t_ext;
        end
    end

    assign cond_res = (c_dec > ssrd_pkg::C_SAT) ? ssrd_pkg::COND_MAX
                                                : c_dec[ssrd_pkg::COND_W-1:0];
    assign temp_res = (t_dec > ssrd_pkg::T_SAT_IN) ? ssrd_pkg::TEMP_MAX
                    : $signed(ssrd_pkg::TEMP_W'(t_dec - ssrd_pkg::T_OFS));

    always_ff @(posedge i_clk) begin
        if (seq_start) begin
            r_pend_cond <= cond_res;
            r_pend_temp <= temp_res;
            r_pend_ovf  <= r_ovf;
        end
    end

    ssrd_seq #(
        .FIELD_BITS (FIELD_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (seq_start),
        .i_raw      (r_diel),
        .i_take     (take),
        .o_stat     (seq_stat),
        .o_moisture (seq_moist)
    );

    assign take = seq_stat.done && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_moist <= seq_moist;
            r_out_cond  <= r_pend_cond;
            r_out_temp  <= r_pend_temp;
            r_out_ovf   <= r_pend_ovf;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.moisture_vwc       = r_out_moist;
    assign o_res.conductivity_centi = r_out_cond;
    assign o_res.temperature_deci   = r_out_temp;
    assign o_res.field_overflow     = r_out_ovf;

    a_cr_returns_to_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && is_cr) |=> (r_phase == P_SEEK) && !r_ovf && (r_facc == '0))
        else $error("Parser did not return to seeking after a carriage return.");

    a_complete_reply_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_start |=> seq_stat.busy)
        else $error("Complete reply did not start the moisture program.");

    a_result_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(seq_stat.done))
        else $error("Result presented without a finished moisture program.");

endmodule

FILE: tb/tb_top.sv
module tb_top;

    localparam int     FIELD_MAX   = (1 << ssrd_pkg::FIELD_BITS_DEF) - 1;
    localparam int     COND_KNEE   = 700;
    localparam int     TEMP_KNEE   = 900;
    localparam int     TEMP_OFFSET = 400;
    localparam int     KNEE_SLOPE  = 5;
    localparam longint TOPP_C3     = 4617;
    localparam longint TOPP_C2     = -590558;
    localparam longint TOPP_C1     = 31353261;
    localparam longint TOPP_C0     = -56908317;
    localparam longint DIEL_MAX    = 64'h7FFFFF;
    localparam longint VWC_LO      = -10000;
    localparam longint VWC_HI      = 20000;
    localparam int     STIM_BYTES  = 1650;
    localparam int     TAIL_CYCLES = 30;
    localparam int     CYCLE_LIMIT = 200000;

    typedef enum logic [3:0] {
        SEEK_DIGIT      = 4'b0001,
        IN_DIELECTRIC   = 4'b0010,
        IN_CONDUCTIVITY = 4'b0100,
        IN_TEMPERATURE  = 4'b1000
    } t_parse_phase;

    typedef struct packed {
        logic signed [15:0] vwc;
        logic [14:0]        cond;
        logic signed [15:0] temp;
        logic               ovf;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    ssrd_rx_if  rx_ch ();
    ssrd_res_if res_ch ();

    soil_sensor_response_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    logic [7:0]   pending_bytes[$];
    t_reading     expected_readings[$];
    int           mismatches;
    int           cycle_count;

    t_parse_phase phase;
    int           diel_raw;
    int           cond_raw;
    int           field_acc;
    logic         ovf_seen;

    int           burst_left;
    int           gap_left;
    int           ready_left;

    always #4 i_clk = ~i_clk;

    function automatic logic signed [15:0] topp_vwc(input int raw);
        longint e;
        longint acc;
        longint v;
        e = (longint'(raw) * 65536 + 25) / 50;
        if (e > DIEL_MAX) begin
            e = DIEL_MAX;
        end
        acc = TOPP_C3;
        acc = ((acc * e + 32768) >>> 16) + TOPP_C2;
        acc = ((acc * e + 32768) >>> 16) + TOPP_C1;
        acc = ((acc * e + 32768) >>> 16) + TOPP_C0;
        v = (acc * 10000 + (longint'(1) << 29)) >>> 30;
        if (v < VWC_LO) begin
            v = VWC_LO;
        end
        if (v > VWC_HI) begin
            v = VWC_HI;
        end
        return 16'(v);
    endfunction

    task automatic clear_reply();
        phase     = SEEK_DIGIT;
        diel_raw  = 0;
        cond_raw  = 0;
        field_acc = 0;
        ovf_seen  = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic     digit;
        int       nxt;
        int       c;
        int       t;
        t_reading want;
        digit = (b >= ssrd_pkg::CH_ZERO) && (b <= ssrd_pkg::CH_NINE);
        if (phase == SEEK_DIGIT) begin
            if (digit) begin
                field_acc = int'(b - ssrd_pkg::CH_ZERO);
                phase     = IN_DIELECTRIC;
            end else if (b == ssrd_pkg::CH_CR) begin
                clear_reply();
            end
        end else if (digit) begin
            nxt = field_acc * 10 + int'(b - ssrd_pkg::CH_ZERO);
            if (nxt > FIELD_MAX) begin
                nxt      = FIELD_MAX;
                ovf_seen = 1'b1;
            end
            field_acc = nxt;
        end else if (b == ssrd_pkg::CH_SP) begin
            if (phase == IN_DIELECTRIC) begin
                diel_raw  = field_acc;
                field_acc = 0;
                phase     = IN_CONDUCTIVITY;
            end else if (phase == IN_CONDUCTIVITY) begin
                cond_raw  = field_acc;
                field_acc = 0;
                phase     = IN_TEMPERATURE;
            end
        end else if (b == ssrd_pkg::CH_CR) begin
            if (phase == IN_TEMPERATURE) begin
                c = cond_raw;
                if (c > COND_KNEE) begin
                    c = KNEE_SLOPE * (c - COND_KNEE) + COND_KNEE;
                end
                t = field_acc;
                if (t > TEMP_KNEE) begin
                    t = KNEE_SLOPE * (t - TEMP_KNEE) + TEMP_KNEE;
                end
                want.vwc  = topp_vwc(diel_raw);
                want.cond = 15'(c);
                want.temp = 16'(t - TEMP_OFFSET);
                want.ovf  = ovf_seen;
                expected_readings.push_back(want);
            end
            clear_reply();
        end
    endtask

    // Leading noise may contain separators; stray bytes inside a field may not.
    function automatic logic [7:0] noise_byte(input logic lead);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= ssrd_pkg::CH_ZERO && b <= ssrd_pkg::CH_NINE) ||
                   (!lead && (b == ssrd_pkg::CH_SP || b == ssrd_pkg::CH_CR)));
        return b;
    endfunction

    function automatic int pick_field();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(695, 705);
            2: return $urandom_range(895, 905);
            3: return $urandom_range(FIELD_MAX - 5, FIELD_MAX + 5);
            4: return $urandom_range(0, 99999);
            default: return $urandom_range(0, FIELD_MAX);
        endcase
    endfunction

    task automatic push_field(input int v, input logic temp_field);
        string txt;
        int    zeros;
        zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        repeat (zeros) pending_bytes.push_back(ssrd_pkg::CH_ZERO);
        txt = $sformatf("%0d", v);
        for (int i = 0; i < txt.len(); i++) begin
            if ($urandom_range(0, 15) == 0) begin
                pending_bytes.push_back(noise_byte(1'b0));
            end
            if (temp_field && $urandom_range(0, 11) == 0) begin
                pending_bytes.push_back(ssrd_pkg::CH_SP);
            end
            pending_bytes.push_back(txt[i]);
        end
    endtask

    // The number of fields given before the carriage return; fewer than three is an
    // abandoned reply.
    task automatic add_reply(input int fields);
        int n_lead;
        n_lead = $urandom_range(0, 2);
        repeat (n_lead) pending_bytes.push_back(noise_byte(1'b1));
        if (fields > 0) begin
            push_field(pick_field(), 1'b0);
        end
        if (fields > 1) begin
            pending_bytes.push_back(ssrd_pkg::CH_SP);
            push_field(pick_field(), 1'b0);
        end
        if (fields > 2) begin
            pending_bytes.push_back(ssrd_pkg::CH_SP);
            push_field(pick_field(), 1'b1);
        end
        pending_bytes.push_back(ssrd_pkg::CH_CR);
    endtask

    task automatic push_reply_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pending_bytes.push_back(s[i]);
        end
        pending_bytes.push_back(ssrd_pkg::CH_CR);
    endtask

    initial begin
        int n;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        clear_reply();

        push_reply_text("x0 0 0");
        push_reply_text("99999 4095 901");
        push_reply_text("7 1");
        while (pending_bytes.size() < STIM_BYTES) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    n = $urandom_range(1, 6);
                    repeat (n) pending_bytes.push_back(8'($urandom_range(0, 255)));
                end
                2, 3, 4: add_reply($urandom_range(0, 2));
                default: add_reply(3);
            endcase
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_bytes.size() != 0 || rx_ch.valid || expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
            burst_left  <= $urandom_range(1, 48);
            gap_left    <= 0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                decode_byte(rx_ch.rx_byte);
            end
            if (rx_ch.valid && !rx_ch.ready) begin
                // The transaction is still pending; hold the byte.
            end else if (gap_left != 0) begin
                gap_left    <= gap_left - 1;
                rx_ch.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= pending_bytes.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            ready_left   <= 0;
        end else if (ready_left == 0) begin
            res_ch.ready <= !res_ch.ready;
            ready_left   <= res_ch.ready ? $urandom_range(1, 9) : $urandom_range(1, 40);
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.vwc  = res_ch.moisture_vwc;
            got.cond = res_ch.conductivity_centi;
            got.temp = res_ch.temperature_deci;
            got.ovf  = res_ch.field_overflow;
            if (expected_readings.size() == 0) begin
                mismatches++;
                $display("%0t unexpected reading: vwc %0d cond %0d temp %0d ovf %0b",
                         $time, got.vwc, got.cond, got.temp, got.ovf);
            end else begin
                want = expected_readings.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t reading mismatch: expected vwc %0d cond %0d temp %0d ovf %0b",
                             $time, want.vwc, want.cond, want.temp, want.ovf);
                    $display("%0t                    actual vwc %0d cond %0d temp %0d ovf %0b",
                             $time, got.vwc, got.cond, got.temp, got.ovf);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
